/* rtl/ffba_pkg.sv */
// ffba_pkg: status codes, opcodes and widths for the first-fit allocator
// no dependencies
`default_nettype none
package ffba_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_NO_SPACE  = 3'd4;
  localparam logic [2:0] ST_ZERO      = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int STATUS_W = 3;
  localparam int LIVE_W   = 7;
  localparam int FIELD_W  = 32;
endpackage
`default_nettype wire

/* rtl/first_fit_block_allocator_unit.sv */
// first_fit_block_allocator_unit: sorted block table held in one memory
// depends on ffba_pkg
//
// usage: raise start with operation, block_size, block_start while busy is
// low; the request is taken at that edge and busy rises. the block walks the
// sorted table through a single synchronous memory (one read port, one write
// port, registered read), reading each entry in S_RD and checking it in
// S_CHK, then for a successful alloc or free shifts the tail of the table
// one place, each entry through S_SHIFT and S_SWAIT. when done, done
// pulses for one cycle with status, granted_start, high_water_mark and
// live_blocks; busy falls in the same cycle and a new request may be taken in
// that cycle. zero size, full table and oversize requests skip the table walk
// and go from the accepting edge straight to S_DONE.
// the receiver cannot stall: the result beat is shown exactly once.
// reset clears the entry count and the high-water mark; the table itself
// holds garbage until written and is only used below the count.
`default_nettype none
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire                 operation,
  input  wire  [FIELD_W-1:0]  block_size,
  input  wire  [FIELD_W-1:0]  block_start,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [FIELD_W-1:0]  granted_start,
  output logic [FIELD_W-1:0]  high_water_mark,
  output logic [LIVE_W-1:0]   live_blocks
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = ADDR_WIDTH + 1;
  localparam logic [AW-1:0] ADDR_LIMIT = {1'b0, {ADDR_WIDTH{1'b1}}};
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // entry = {start, size}
  logic [2*ADDR_WIDTH-1:0] mem [MAX_BLOCKS];
  logic [2*ADDR_WIDTH-1:0] rd_data;
  logic [IW-1:0]           rd_addr;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [2*ADDR_WIDTH-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic [AW-1:0]         high_water;
  logic                  op;
  logic [AW-1:0]         req_size;
  logic [AW-1:0]         req_start;
  logic [CW-1:0]         pos;
  logic [AW-1:0]         gap_base;
  logic [CW-1:0]         k;
  logic [2*ADDR_WIDTH-1:0] carry;
  logic [STATUS_W-1:0]   res_status;
  logic [AW-1:0]         res_grant;

  logic [AW-1:0] e_start, e_size, e_end, ins_end;
  logic          fit;
  assign e_start = {1'b0, rd_data[2*ADDR_WIDTH-1:ADDR_WIDTH]};
  assign e_size  = {1'b0, rd_data[ADDR_WIDTH-1:0]};
  assign e_end   = e_start + e_size;
  assign fit     = (e_start >= gap_base) && ((e_start - gap_base) >= req_size);
  assign ins_end = gap_base + req_size;

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_addr = pos[IW-1:0];
    if (state == S_SHIFT || state == S_SWAIT) rd_addr = k[IW-1:0];
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    done  <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      high_water <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          op        <= operation;
          req_size  <= AW'(block_size[ADDR_WIDTH <= FIELD_W ? ADDR_WIDTH-1 : FIELD_W-1 : 0]);
          req_start <= AW'(block_start[ADDR_WIDTH <= FIELD_W ? ADDR_WIDTH-1 : FIELD_W-1 : 0]);
          pos       <= '0;
          gap_base  <= '0;
          res_grant <= '0;
          if (operation == OP_ALLOC && block_size == '0) begin
            res_status <= ST_ZERO; state <= S_DONE;
          end else if (operation == OP_ALLOC && count >= MAX_C) begin
            res_status <= ST_FULL; state <= S_DONE;
          end else if (operation == OP_ALLOC && FIELD_W > ADDR_WIDTH &&
                       (AW+FIELD_W)'(block_size) > (AW+FIELD_W)'(ADDR_LIMIT)) begin
            res_status <= ST_NO_SPACE; state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (pos == count) begin
            // end of table reached
            if (op == OP_FREE) begin
              res_status <= ST_NOT_FOUND; state <= S_DONE;
            end else if (gap_base > ADDR_LIMIT - req_size) begin
              res_status <= ST_NO_SPACE; state <= S_DONE;
            end else begin
              res_status <= ST_OK;
              res_grant  <= gap_base;
              wr_en      <= 1'b1;
              wr_addr    <= pos[IW-1:0];
              wr_data    <= {gap_base[ADDR_WIDTH-1:0], req_size[ADDR_WIDTH-1:0]};
              count      <= count + 1'b1;
              if (ins_end > high_water) high_water <= ins_end;
              state      <= S_DONE;
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (op == OP_ALLOC) begin
            if (fit) begin
              if (gap_base > ADDR_LIMIT - req_size) begin
                res_status <= ST_NO_SPACE; state <= S_DONE;
              end else begin
                // write new entry, carry old one up the table
                res_status <= ST_OK;
                res_grant  <= gap_base;
                wr_en      <= 1'b1;
                wr_addr    <= pos[IW-1:0];
                wr_data    <= {gap_base[ADDR_WIDTH-1:0], req_size[ADDR_WIDTH-1:0]};
                carry      <= rd_data;
                k          <= pos + 1'b1;
                state      <= S_SHIFT;
              end
            end else begin
              gap_base <= e_end;
              pos      <= pos + 1'b1;
              state    <= S_RD;
            end
          end else begin
            if (e_start == req_start) begin
              if (e_size != req_size) begin
                res_status <= ST_MISMATCH; state <= S_DONE;
              end else begin
                res_status <= ST_OK;
                k          <= pos + 1'b1;
                state      <= S_SHIFT;
              end
            end else begin
              pos   <= pos + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_SHIFT: begin
          // alloc: k runs to count (inclusive write); free: k runs to count-1
          if (op == OP_ALLOC && k == count) begin
            wr_en   <= 1'b1;
            wr_addr <= k[IW-1:0];
            wr_data <= carry;
            count   <= count + 1'b1;
            state   <= S_DONE;
          end else if (op == OP_FREE && k == count) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          wr_en <= 1'b1;
          if (op == OP_ALLOC) begin
            wr_addr <= k[IW-1:0];
            wr_data <= carry;
            carry   <= rd_data;
          end else begin
            wr_addr <= IW'(k - 1'b1);
            wr_data <= rd_data;
          end
          k     <= k + 1'b1;
          state <= S_SHIFT;
        end
        S_DONE: begin
          done            <= 1'b1;
          status          <= res_status;
          granted_start   <= FIELD_W'(res_grant);
          high_water_mark <= FIELD_W'(high_water);
          live_blocks     <= LIVE_W'(count);
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ffba_checker.sv */
// ffba_checker: port-level assertions for the allocator, bound to the top
// depends on ffba_pkg
`default_nettype none
module ffba_checker
  import ffba_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input wire                done,
  input wire [STATUS_W-1:0] status,
  input wire [FIELD_W-1:0]  granted_start
);
  // an accepted beat makes the block busy
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept without busy");
  // a result beat ends the busy period
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");
  a_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> granted_start == '0) else $error("grant on error");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_ZERO) else $error("bad status");
endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .status(status), .granted_start(granted_start)
);
`default_nettype wire

/* dv/ffba_checker.sv */
// ffba_scoreboard: watches the request and result ports of the allocator,
// keeps its own copy of the block table and compares every result beat
// depends on ffba_pkg
module ffba_scoreboard
  import ffba_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 busy,
  input  wire                 operation,
  input  wire  [FIELD_W-1:0]  block_size,
  input  wire  [FIELD_W-1:0]  block_start,
  input  wire                 done,
  input  wire  [STATUS_W-1:0] status,
  input  wire  [FIELD_W-1:0]  granted_start,
  input  wire  [FIELD_W-1:0]  high_water_mark,
  input  wire  [LIVE_W-1:0]   live_blocks,
  output int                  fail_count,
  output int                  pending,
  output int                  checked,
  output int                  full_seen,
  output int                  nospace_seen
);
  localparam int TABLE_DEPTH = 64;
  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  granted;
    logic [FIELD_W-1:0]  hwm;
    logic [LIVE_W-1:0]   live;
  } alloc_result_t;

  logic [63:0] tbl_start [TABLE_DEPTH];
  logic [63:0] tbl_size [TABLE_DEPTH];
  int unsigned tbl_count;
  logic [63:0] hwm_model;
  alloc_result_t expected_q[$];

  task automatic model_request(input logic op, input logic [63:0] sz,
                               input logic [63:0] st, output alloc_result_t r);
    logic [63:0] gap_base;
    int unsigned pos;
    int unsigned idx;
    bit found;
    r = '0;
    if (op == OP_ALLOC) begin
      if (sz == 0) begin
        r.status = ST_ZERO;
      end else if (tbl_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        gap_base = 0;
        pos = tbl_count;
        found = 0;
        // first gap from address zero that fits
        for (int i = 0; i < tbl_count; i++) begin
          if (!found) begin
            if (tbl_start[i] >= gap_base && tbl_start[i] - gap_base >= sz) begin
              pos = i;
              found = 1;
            end else begin
              gap_base = tbl_start[i] + tbl_size[i];
            end
          end
        end
        if (gap_base > ADDR_MAX - sz) begin
          r.status = ST_NO_SPACE;
        end else begin
          for (int k = tbl_count; k > pos; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k] = tbl_size[k-1];
          end
          tbl_start[pos] = gap_base;
          tbl_size[pos] = sz;
          tbl_count++;
          if (pos + 1 == tbl_count && gap_base + sz > hwm_model)
            hwm_model = gap_base + sz;
          r.status = ST_OK;
          r.granted = gap_base[31:0];
        end
      end
    end else begin
      idx = tbl_count;
      for (int i = tbl_count - 1; i >= 0; i--)
        if (tbl_start[i] == st) idx = i;
      if (idx >= tbl_count) begin
        r.status = ST_NOT_FOUND;
      end else if (tbl_size[idx] != sz) begin
        r.status = ST_MISMATCH;
      end else begin
        for (int k = idx; k + 1 < tbl_count; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_size[k] = tbl_size[k+1];
        end
        tbl_count--;
        r.status = ST_OK;
      end
    end
    r.hwm = hwm_model[31:0];
    r.live = tbl_count[LIVE_W-1:0];
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    alloc_result_t got;
    if (rst) begin
      tbl_count = 0;
      hwm_model = 0;
      expected_q.delete();
    end else begin
      if (start && !busy) begin
        model_request(operation, {32'd0, block_size}, {32'd0, block_start}, exp_r);
        if (exp_r.status == ST_FULL) full_seen++;
        if (exp_r.status == ST_NO_SPACE) nospace_seen++;
        expected_q.push_back(exp_r);
      end
      if (done) begin
        got = '{status, granted_start, high_water_mark, live_blocks};
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d granted %h hwm %h live %0d",
                     status, granted_start, high_water_mark, live_blocks);
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp status %0d granted %h hwm %h live %0d / got %0d %h %h %0d",
                       exp_r.status, exp_r.granted, exp_r.hwm, exp_r.live,
                       status, granted_start, high_water_mark, live_blocks);
          end
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    full_seen = 0;
    nospace_seen = 0;
    tbl_count = 0;
    hwm_model = 0;
  end
endmodule

/* dv/tb_top.sv */
// tb_top: request stimulus for the first-fit allocator, verdict and watchdog
// depends on ffba_pkg, first_fit_block_allocator_unit and ffba_scoreboard
module tb_top;
  import ffba_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1730;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic operation = OP_ALLOC;
  logic [FIELD_W-1:0] block_size = '0;
  logic [FIELD_W-1:0] block_start = '0;
  wire busy, done;
  wire [STATUS_W-1:0] status;
  wire [FIELD_W-1:0] granted_start, high_water_mark;
  wire [LIVE_W-1:0] live_blocks;
  int fail_count, pending, checked, full_seen, nospace_seen;
  int idle_pct;
  int stall_cycles;

  // blocks this side believes are held, learnt from the result beats
  logic [31:0] held_start[$];
  logic [31:0] held_size[$];
  logic last_op;
  logic [31:0] last_size, last_start;

  always #6 clk = ~clk;

  first_fit_block_allocator_unit dut (
    .clk, .rst, .start, .busy, .operation, .block_size, .block_start,
    .done, .status, .granted_start, .high_water_mark, .live_blocks
  );

  ffba_scoreboard u_checker (
    .clk, .rst, .start, .busy, .operation, .block_size, .block_start,
    .done, .status, .granted_start, .high_water_mark, .live_blocks,
    .fail_count, .pending, .checked, .full_seen, .nospace_seen
  );

  always @(posedge clk) begin
    if (!rst && done && status == ST_OK) begin
      if (last_op == OP_ALLOC) begin
        held_start.push_back(granted_start);
        held_size.push_back(last_size);
      end else begin
        foreach (held_start[i])
          if (held_start[i] == last_start) begin
            held_start.delete(i);
            held_size.delete(i);
            break;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one beat: optional idle gap, present, wait for acceptance, then the result
  task automatic send_request(input logic op, input logic [31:0] sz,
                              input logic [31:0] st);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    operation <= op;
    block_size <= sz;
    block_start <= st;
    do @(posedge clk); while (!(start && !busy));
    last_op = op;
    last_size = sz;
    last_start = st;
    @(negedge clk);
    start <= 0;
    // let the result come back so the held list is current
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_request(input int alloc_pct);
    int pick, roll;
    logic [31:0] sz;
    roll = $urandom_range(99);
    if (roll < alloc_pct || held_start.size() == 0) begin
      roll = $urandom_range(99);
      if (roll < 3) sz = 0;
      else if (roll < 6) sz = $urandom();
      else if (roll < 20) sz = $urandom_range(64, 1);
      else sz = $urandom_range(12, 1);
      send_request(OP_ALLOC, sz, $urandom());
    end else begin
      pick = $urandom_range(held_start.size() - 1);
      roll = $urandom_range(99);
      if (roll < 80) send_request(OP_FREE, held_size[pick], held_start[pick]);
      else if (roll < 90) send_request(OP_FREE, held_size[pick] ^ (32'd1 << $urandom_range(31)),
                                       held_start[pick]);
      else send_request(OP_FREE, $urandom(), $urandom());
    end
  endtask

  initial begin
    int alloc_pct;
    idle_pct = 0;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: zero size, whole address space, mismatch, unknown start
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'd1, 32'hA5A5_5A5A);
    send_request(OP_FREE, 32'hFFFF_FFFE, 32'd0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'h8000_0000, 32'h5A5A_A5A5);
    send_request(OP_ALLOC, 32'h7FFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_FREE, 32'h8000_0000, 32'd0);
    send_request(OP_ALLOC, 32'd16, 32'd0);
    send_request(OP_ALLOC, 32'd4, 32'd0);
    send_request(OP_FREE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_ALLOC, 32'd8, 32'd0);
    send_request(OP_FREE, 32'd16, 32'd0);
    send_request(OP_ALLOC, 32'd3, 32'd0);
    send_request(OP_FREE, 32'd4, 32'd16);
    send_request(OP_FREE, 32'd8, 32'd20);
    send_request(OP_FREE, 32'd3, 32'd0);

    // random: four idle phases, alloc bias swings so the table fills and drains
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n * 4) / RANDOM_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 0;
        default: idle_pct = 19;
      endcase
      alloc_pct = ((n / 150) % 2 == 0) ? 80 : 30;
      random_request(alloc_pct);
    end

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("%0d results checked; table-full seen %0d times, out of space %0d times",
             checked, full_seen, nospace_seen);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator_unit.sv
rtl/ffba_checker.sv
dv/ffba_checker.sv
dv/tb_top.sv
